// File: rtl/min_tracking_stack_assert.svh
// Assertion macros for the min tracking stack checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mts_pkg.sv
package mts_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_WORD_WIDTH  = 32;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // request kinds; the unused code behaves as a query
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

// File: rtl/mts_in_if.sv
interface mts_in_if
  import mts_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic        [KIND_W-1:0]     kind;
  logic signed [WORD_WIDTH-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// File: rtl/mts_out_if.sv
interface mts_out_if
  import mts_pkg::*;
#(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int CNT_W      = $clog2(DEF_STACK_DEPTH + 1)
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] top_value;
  logic signed [WORD_WIDTH-1:0] min_value;
  logic        [CNT_W-1:0]      depth_used;
  logic                         is_empty;
  logic                         is_full;
  logic        [STATUS_W-1:0]   status;

  modport source (output valid, output top_value, output min_value, output depth_used,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input depth_used,
                  input is_empty, input is_full, input status, output ready);
endinterface

// File: rtl/mts_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module mts_ram
  import mts_pkg::*;
#(
  parameter int DEPTH  = DEF_STACK_DEPTH,
  parameter int WIDTH  = DEF_WORD_WIDTH,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/min_tracking_stack.sv
// Min tracking stack. Each request is a push, a pop or a query (the unused
// kind code acts as a query); every request gives exactly one response with
// the top word, the running minimum, the fill level, empty/full flags and a
// status (ok, overflow: push dropped, underflow: pop ignored). An empty stack
// reports top 0 and minimum all ones. Words and minima live in two RAMs with
// a registered read port; the current top word and top minimum are held in
// registers, so push and query finish in the cycle they are accepted and a
// response follows on the next edge. A pop that leaves entries below it passes
// through S_READ, as the new top (and, when the minimum goes too, the new
// minimum) must come back from the RAM read port; an ignored pop or a pop of
// the last entry skips S_READ. The next request is taken while a response waits
// in the output register, as long as the sink takes it in the same cycle.
// Nothing is cleared in the RAMs after reset, so requests are taken at once.
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  mts_in_if.sink    in_req,
  mts_out_if.source out_rsp
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                         state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;      // words held
  logic [CNT_W-1:0]             mcnt_r, mcnt_nxt;    // minima held
  logic signed [WORD_WIDTH-1:0] top_r, top_nxt;      // cached top word
  logic signed [WORD_WIDTH-1:0] mtop_r, mtop_nxt;    // cached top minimum
  logic                         val_pend_r, val_pend_nxt;
  logic                         min_pend_r, min_pend_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [WORD_WIDTH-1:0] out_top_r, out_min_r;
  logic [CNT_W-1:0]             out_depth_r;
  logic                         out_empty_r, out_full_r;
  logic [STATUS_W-1:0]          out_status_r, status_nxt;
  logic                         load_out;

  logic                         in_fire;
  logic                         is_push, is_pop;
  logic                         push_ok, min_push, pop_ok, min_pop;
  logic [CNT_W-1:0]             cnt_dec, mcnt_dec, cnt_dec2, mcnt_dec2;

  logic                         val_we, val_re, min_we, min_re;
  logic [WORD_WIDTH-1:0]        val_rdata, min_rdata;

  // --- request decode --------------------------------------------------
  assign in_req.ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_fire      = in_req.valid && in_req.ready;

  assign is_push = (in_req.kind == KIND_PUSH);
  assign is_pop  = (in_req.kind == KIND_POP);

  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign mcnt_dec  = mcnt_r - CNT_W'(1);
  assign cnt_dec2  = cnt_dec - CNT_W'(1);
  assign mcnt_dec2 = mcnt_dec - CNT_W'(1);

  // Equal values count as new minima so duplicates of the minimum are kept.
  assign push_ok  = is_push && (cnt_r < CNT_W'(STACK_DEPTH));
  assign min_push = push_ok && (mcnt_r < CNT_W'(STACK_DEPTH)) &&
                    ((mcnt_r == '0) || (in_req.push_value <= mtop_r));
  assign pop_ok   = is_pop && (cnt_r != '0);
  assign min_pop  = pop_ok && (mcnt_r != '0) && (mtop_r == top_r);

  // --- RAM ports ---------------------------------------------------------
  // Writes land at the current fill level; a pop fetches the entry that
  // becomes the new top, i.e. two below the old fill level.
  assign val_we = in_fire && push_ok;
  assign min_we = in_fire && min_push;
  assign val_re = in_fire && pop_ok && (cnt_r > CNT_W'(1));
  assign min_re = in_fire && min_pop && (mcnt_r > CNT_W'(1));

  mts_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (WORD_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_req.push_value),
    .re    (val_re),
    .raddr (cnt_dec2[ADDR_W-1:0]),
    .rdata (val_rdata)
  );

  mts_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (WORD_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (mcnt_r[ADDR_W-1:0]),
    .wdata (in_req.push_value),
    .re    (min_re),
    .raddr (mcnt_dec2[ADDR_W-1:0]),
    .rdata (min_rdata)
  );

  // --- next state ---------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mcnt_nxt     = mcnt_r;
    top_nxt      = top_r;
    mtop_nxt     = mtop_r;
    val_pend_nxt = val_pend_r;
    min_pend_nxt = min_pend_r;
    status_nxt   = STATUS_OK;
    load_out     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_push) begin
            if (push_ok) begin
              cnt_nxt = cnt_r + CNT_W'(1);
              top_nxt = in_req.push_value;
              if (min_push) begin
                mcnt_nxt = mcnt_r + CNT_W'(1);
                mtop_nxt = in_req.push_value;
              end
            end else begin
              status_nxt = STATUS_OVERFLOW;
            end
            load_out = 1'b1;
          end else if (is_pop) begin
            if (pop_ok) begin
              cnt_nxt = cnt_dec;
              if (min_pop) begin
                mcnt_nxt = mcnt_dec;
              end
              if (val_re || min_re) begin
                // wait in S_READ for the RAM read data
                state_nxt    = S_READ;
                val_pend_nxt = val_re;
                min_pend_nxt = min_re;
              end else begin
                load_out = 1'b1;
              end
            end else begin
              status_nxt = STATUS_UNDERFLOW;
              load_out   = 1'b1;
            end
          end else begin
            load_out = 1'b1;
          end
        end
      end
      S_READ: begin
        if (val_pend_r) begin
          top_nxt = val_rdata;
        end
        if (min_pend_r) begin
          mtop_nxt = min_rdata;
        end
        val_pend_nxt = 1'b0;
        min_pend_nxt = 1'b0;
        state_nxt    = S_IDLE;
        load_out     = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output slot is always free (or draining) when load_out is raised.
  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      val_pend_r  <= 1'b0;
      min_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mcnt_r      <= mcnt_nxt;
      val_pend_r  <= val_pend_nxt;
      min_pend_r  <= min_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    mtop_r <= mtop_nxt;
    if (load_out) begin
      out_top_r    <= (cnt_nxt != '0) ? top_nxt : '0;
      out_min_r    <= ((cnt_nxt != '0) && (mcnt_nxt != '0)) ? mtop_nxt : '1;
      out_depth_r  <= cnt_nxt;
      out_empty_r  <= (cnt_nxt == '0);
      out_full_r   <= (cnt_nxt == CNT_W'(STACK_DEPTH));
      out_status_r <= status_nxt;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.top_value  = out_top_r;
  assign out_rsp.min_value  = out_min_r;
  assign out_rsp.depth_used = out_depth_r;
  assign out_rsp.is_empty   = out_empty_r;
  assign out_rsp.is_full    = out_full_r;
  assign out_rsp.status     = out_status_r;

endmodule

// File: rtl/mts_checker.sv
`include "min_tracking_stack_assert.svh"

module mts_checker
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH,
  parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [WORD_WIDTH-1:0] top_value,
  input logic [WORD_WIDTH-1:0] min_value,
  input logic [CNT_W-1:0]      depth_used,
  input logic                  is_empty,
  input logic                  is_full,
  input logic [STATUS_W-1:0]   status
);

  `MTS_ASSERT_SAME(a_empty_flag, out_valid, is_empty == (depth_used == '0), "empty flag disagrees with level")
  `MTS_ASSERT_SAME(a_full_flag, out_valid, is_full == (depth_used == CNT_W'(STACK_DEPTH)), "full flag disagrees with level")
  `MTS_ASSERT_SAME(a_empty_words, out_valid && is_empty, (top_value == '0) && (min_value == '1), "empty stack words wrong")
  `MTS_ASSERT_SAME(a_status_level, out_valid, ((status != STATUS_UNDERFLOW) || is_empty) && ((status != STATUS_OVERFLOW) || is_full), "status inconsistent with level")
  `MTS_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(top_value) && $stable(min_value) && $stable(status), "stalled response changed")

endmodule

bind min_tracking_stack mts_checker #(
  .STACK_DEPTH (STACK_DEPTH),
  .WORD_WIDTH  (WORD_WIDTH)
) u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .top_value  (out_rsp.top_value),
  .min_value  (out_rsp.min_value),
  .depth_used (out_rsp.depth_used),
  .is_empty   (out_rsp.is_empty),
  .is_full    (out_rsp.is_full),
  .status     (out_rsp.status)
);
